@@ src/shb_pkg.sv @@
`timescale 1ns / 1ps
package shb_pkg;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam logic [7:0] PAD_MARK    = 8'h80;
  localparam logic [5:0] LEN_POS     = 6'd56;
  localparam int         HASH_WORDS  = 8;
  localparam int         BLOCK_WORDS = 16;
  localparam int         ROUNDS      = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOADH,
    ST_LOADW,
    ST_ROUND,
    ST_STORE,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_t;

  // which block is being compressed
  typedef enum logic [1:0] {
    PH_DATA,
    PH_PAD1,
    PH_PAD2
  } phase_t;

  typedef struct packed {
    logic h_shift;
    logic w_shift;
    logic rnd;
    logic v_shift;
  } core_ctrl_t;

  typedef struct packed {
    phase_t      phase;
    logic [5:0]  fill;
    logic [63:0] total;
    logic [3:0]  widx;
  } pad_info_t;

  function automatic logic [31:0] hash_iv(input logic [2:0] i);
    logic [31:0] r;
    unique case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      3'd7: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] r;
    unique case (t)
      6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7; 6'd63: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage

@@ src/shb_in_if.sv @@
`timescale 1ns / 1ps
interface shb_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, kind, data_byte, input ready);
  modport sink (input valid, kind, data_byte, output ready);
endinterface

@@ src/shb_out_if.sv @@
`timescale 1ns / 1ps
interface shb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ src/shb_buf.sv @@
`timescale 1ns / 1ps
module shb_buf (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [3:0]  wr_addr,
  input  logic [1:0]  wr_lane,
  input  logic [7:0]  wr_byte,
  input  logic        rd_en,
  input  logic [3:0]  rd_addr,
  output logic [31:0] rd_data
);
  import shb_pkg::*;

  logic [31:0] mem [BLOCK_WORDS];
  logic [31:0] rd_data_r;

  // byte 0 of a word sits in the top lane
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int k = 0; k < 4; k++) begin
        if (wr_lane == 2'(3 - k)) begin
          mem[wr_addr][8*k +: 8] <= wr_byte;
        end
      end
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

@@ src/shb_hash.sv @@
`timescale 1ns / 1ps
module shb_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        clr,
  input  logic        wr_en,
  input  logic [2:0]  wr_addr,
  input  logic [31:0] wr_data,
  input  logic        rd_en,
  input  logic [2:0]  rd_addr,
  output logic [31:0] rd_data
);
  import shb_pkg::*;

  logic [31:0]           mem [HASH_WORDS];
  logic [HASH_WORDS-1:0] valid_r;
  logic [31:0]           rd_data_r;
  logic                  rd_valid_r;
  logic [2:0]            rd_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r  <= mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
      rd_idx_r   <= rd_addr;
    end
  end

  // unwritten entries read as the initial hash value
  assign rd_data = rd_valid_r ? rd_data_r : hash_iv(rd_idx_r);
endmodule

@@ src/shb_core.sv @@
`timescale 1ns / 1ps
module shb_core (
  input  logic                clk,
  input  shb_pkg::core_ctrl_t ctrl,
  input  shb_pkg::pad_info_t  pad,
  input  logic [5:0]          rnd_idx,
  input  logic [31:0]         h_rd,
  input  logic [31:0]         buf_rd,
  output logic [31:0]         v_head
);
  import shb_pkg::*;

  logic [31:0] v_r [HASH_WORDS];
  logic [31:0] w_r [BLOCK_WORDS];
  logic [31:0] w_in;
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [63:0] len_bits;
  logic        len_here;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // padded message word: buffer bytes, marker, zeros, bit length
  always_comb begin
    logic [5:0] p;
    len_bits = {pad.total[60:0], 3'b000};
    len_here = (pad.phase == PH_PAD2) || (pad.phase == PH_PAD1 && pad.fill < LEN_POS);
    w_in = '0;
    for (int k = 0; k < 4; k++) begin
      p = {pad.widx, 2'(k)};
      if (pad.phase == PH_DATA || (pad.phase == PH_PAD1 && p < pad.fill)) begin
        w_in[8*(3-k) +: 8] = buf_rd[8*(3-k) +: 8];
      end else if (pad.phase == PH_PAD1 && p == pad.fill) begin
        w_in[8*(3-k) +: 8] = PAD_MARK;
      end else if (len_here && p >= LEN_POS) begin
        w_in[8*(3-k) +: 8] = len_bits[8*(7 - 32'(p[2:0])) +: 8];
      end
    end
  end

  always_comb begin
    w_new = (rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10)) + w_r[9]
          + (rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3)) + w_r[0];
    t1 = v_r[7] + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25))
       + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + round_k(rnd_idx) + w_r[0];
    t2 = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22))
       + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  // message schedule window, w_r[0] is the current round word
  always_ff @(posedge clk) begin
    if (ctrl.w_shift || ctrl.rnd) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[BLOCK_WORDS-1] <= ctrl.w_shift ? w_in : w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.h_shift || ctrl.v_shift) begin
      for (int i = 0; i < HASH_WORDS - 1; i++) begin
        v_r[i] <= v_r[i+1];
      end
      v_r[HASH_WORDS-1] <= ctrl.h_shift ? h_rd : v_r[0];
    end else if (ctrl.rnd) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  assign v_head = v_r[0];
endmodule

@@ src/sha256_stream_hasher_top.sv @@
`timescale 1ns / 1ps
// streaming sha-256: each input item carries one message byte (kind 0) or closes the
// message (kind 1); a close returns the eight digest words h0..h7 as eight result items,
// last_word set on h7, after which the engine is back at its initial hash for the next
// message. the byte that completes a 64-byte block adds a compression (read the hash
// memory, read the block buffer memory, 64 rounds on the single round unit, add back into
// the hash memory), and no new item is taken until it is done. a close costs one or two
// compressions (two when 56 or more bytes are waiting in the buffer) and then reads each
// digest word from the hash memory and registers it while the output side takes them.
// during a compression the hash memory and buffer memory each move one word a cycle,
// and the round unit does one round a cycle.
module sha256_stream_hasher_top (
  input logic       clk,
  input logic       rst_n,
  shb_in_if.sink    in_ch,
  shb_out_if.source out_ch
);
  import shb_pkg::*;

  state_t      state_r, state_nxt;
  phase_t      phase_r;
  logic [5:0]  cnt_r;
  logic [5:0]  fill_r;
  logic [63:0] total_r;

  logic        out_valid_r;
  logic [31:0] out_word_r;
  logic [2:0]  out_idx_r;
  logic        out_last_r;

  logic        in_fire;
  logic        out_free;
  logic        cnt_done;

  // memory ports
  logic        buf_wr, buf_rd_en, h_wr, h_rd_en, h_clr;
  logic [3:0]  buf_rd_addr;
  logic [2:0]  h_rd_addr, h_wr_addr;
  logic [31:0] buf_rd, h_rd, v_head;

  core_ctrl_t  ctrl;
  pad_info_t   pad;

  assign in_fire  = in_ch.valid && in_ch.ready;
  // slot is free next cycle if empty now or taken now
  assign out_free = !out_valid_r || out_ch.ready;

  // loop end for the current phase of a compression
  always_comb begin
    unique case (state_r)
      ST_LOADH: cnt_done = (cnt_r == 6'(HASH_WORDS));
      ST_LOADW: cnt_done = (cnt_r == 6'(BLOCK_WORDS));
      ST_ROUND: cnt_done = (cnt_r == 6'(ROUNDS - 1));
      ST_STORE: cnt_done = (cnt_r == 6'(HASH_WORDS));
      default:  cnt_done = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.kind == KIND_FINISH || fill_r == 6'd63) begin
            state_nxt = ST_LOADH;
          end
        end
      end
      ST_LOADH: if (cnt_done) state_nxt = ST_LOADW;
      ST_LOADW: if (cnt_done) state_nxt = ST_ROUND;
      ST_ROUND: if (cnt_done) state_nxt = ST_STORE;
      ST_STORE: begin
        if (cnt_done) begin
          priority if (phase_r == PH_DATA) begin
            state_nxt = ST_IDLE;
          end else if (phase_r == PH_PAD1 && fill_r >= LEN_POS) begin
            state_nxt = ST_LOADH;
          end else begin
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      ST_EMIT_RD: if (out_free) state_nxt = ST_EMIT_WR;
      ST_EMIT_WR: state_nxt = (cnt_r[2:0] == 3'd7) ? ST_IDLE : ST_EMIT_RD;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    buf_wr      = 1'b0;
    buf_rd_en   = 1'b0;
    buf_rd_addr = cnt_r[3:0];
    h_rd_en     = 1'b0;
    h_rd_addr   = cnt_r[2:0];
    h_wr        = 1'b0;
    h_wr_addr   = 3'(cnt_r - 6'd1);
    h_clr       = 1'b0;
    ctrl        = '0;
    unique case (state_r)
      ST_IDLE: buf_wr = in_fire && (in_ch.kind == KIND_DATA);
      ST_LOADH: begin
        h_rd_en      = (cnt_r < 6'(HASH_WORDS));
        ctrl.h_shift = (cnt_r != 6'd0);
      end
      ST_LOADW: begin
        buf_rd_en    = (cnt_r < 6'(BLOCK_WORDS));
        ctrl.w_shift = (cnt_r != 6'd0);
      end
      ST_ROUND: ctrl.rnd = 1'b1;
      ST_STORE: begin
        // read-add-write back, write trails read by one entry
        h_rd_en      = (cnt_r < 6'(HASH_WORDS));
        h_wr         = (cnt_r != 6'd0);
        ctrl.v_shift = (cnt_r != 6'd0);
      end
      ST_EMIT_RD: h_rd_en = out_free;
      ST_EMIT_WR: h_clr = (cnt_r[2:0] == 3'd7);
      default: ;
    endcase
  end

  assign pad.phase = phase_r;
  assign pad.fill  = fill_r;
  assign pad.total = total_r;
  assign pad.widx  = 4'(cnt_r - 6'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_DATA;
      cnt_r       <= '0;
      fill_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          if (in_fire) begin
            if (in_ch.kind == KIND_DATA) begin
              fill_r  <= fill_r + 6'd1;
              total_r <= total_r + 64'd1;
              phase_r <= PH_DATA;
            end else begin
              phase_r <= PH_PAD1;
            end
          end
        end
        ST_LOADH, ST_LOADW, ST_ROUND: begin
          cnt_r <= cnt_done ? 6'd0 : cnt_r + 6'd1;
        end
        ST_STORE: begin
          cnt_r <= cnt_done ? 6'd0 : cnt_r + 6'd1;
          if (cnt_done && phase_r == PH_PAD1 && fill_r >= LEN_POS) begin
            phase_r <= PH_PAD2;
          end
        end
        ST_EMIT_RD: ;
        ST_EMIT_WR: begin
          out_valid_r <= 1'b1;
          if (cnt_r[2:0] == 3'd7) begin
            // message closed, fresh state for the next one
            cnt_r   <= '0;
            fill_r  <= '0;
            total_r <= '0;
            phase_r <= PH_DATA;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT_WR) begin
      out_word_r <= h_rd;
      out_idx_r  <= cnt_r[2:0];
      out_last_r <= (cnt_r[2:0] == 3'd7);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.digest_word = out_word_r;
  assign out_ch.word_index  = out_idx_r;
  assign out_ch.last_word   = out_last_r;

  shb_buf u_buf (
    .clk     (clk),
    .wr_en   (buf_wr),
    .wr_addr (fill_r[5:2]),
    .wr_lane (fill_r[1:0]),
    .wr_byte (in_ch.data_byte),
    .rd_en   (buf_rd_en),
    .rd_addr (buf_rd_addr),
    .rd_data (buf_rd)
  );

  shb_hash u_hash (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (h_clr),
    .wr_en   (h_wr),
    .wr_addr (h_wr_addr),
    .wr_data (h_rd + v_head),
    .rd_en   (h_rd_en),
    .rd_addr (h_rd_addr),
    .rd_data (h_rd)
  );

  shb_core u_core (
    .clk     (clk),
    .ctrl    (ctrl),
    .pad     (pad),
    .rnd_idx (cnt_r),
    .h_rd    (h_rd),
    .buf_rd  (buf_rd),
    .v_head  (v_head)
  );
endmodule
